// ===== rtl/sacts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacts_pkg
// shared types and constants of the set-associative tag store
// ----------------------------------------------------------------------------
package sacts_pkg;

   localparam int ADDR_W   = 48;
   localparam int STAMP_W  = 64;
   localparam int CTR_W    = 3;
   localparam int LFSR_W   = 16;
   localparam int POL_W    = 2;
   localparam int TYPE_W   = 3;
   localparam int RSP_W    = 72;
   localparam int MOD_STEP = 4;

   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;
   localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;
   localparam logic [CTR_W-1:0]  CTR_HIT   = 3'd7;
   localparam logic [CTR_W-1:0]  CTR_NEW   = 3'd1;

   localparam logic [POL_W-1:0] POL_RANDOM = 2'd1;
   localparam logic [POL_W-1:0] POL_REUSE  = 2'd2;

   typedef enum logic [TYPE_W-1:0] {
      REQ_ACCESS     = 3'd0,
      REQ_PROBE      = 3'd1,
      REQ_INVALIDATE = 3'd2,
      REQ_DIRTY      = 3'd3,
      REQ_INSTALL    = 3'd4
   } req_code_type;

   typedef struct packed {
      logic              valid;
      logic [TYPE_W-1:0] rtype;
      logic [ADDR_W-1:0] addr;
   } req_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_RMOD,
      ST_SCAN,
      ST_APPLY
   } back_state_type;

endpackage

// ===== rtl/sacts_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacts_front
// request intake: set index reduction and a two-entry request queue
// ----------------------------------------------------------------------------
module sacts_front import sacts_pkg::*; #(
   parameter int NUM_SETS = 1024,
   parameter int SET_W    = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TYPE_W-1:0]     req_tuser,
   input  logic [ADDR_W-1:0]     req_tdata,
   input  back_status_type       status,
   output req_head_type          head,
   output logic [SET_W-1:0]      head_set
);

   localparam bit IS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
   localparam int STEPS   = ADDR_W / MOD_STEP;
   localparam int CNT_W   = $clog2(STEPS + 1);

   logic              busy_ff, busy_in;
   logic [TYPE_W-1:0] rtype_ff, rtype_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] sh_ff, sh_in;
   logic [SET_W:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [TYPE_W-1:0] q_rtype_ff [2];
   logic [ADDR_W-1:0] q_addr_ff  [2];
   logic [SET_W-1:0]  q_set_ff   [2];
   logic              wp_ff, rp_ff;
   logic [1:0]        count_ff;

   logic              accept, done, push, pop;
   logic [SET_W-1:0]  set_val;
   logic [SET_W:0]    r;

   assign req_tready = !busy_ff && !status.clearing;
   assign accept     = req_tvalid && req_tready;
   assign done       = IS_POW2 ? 1'b1 : (cnt_ff == CNT_W'(STEPS));
   assign push       = busy_ff && done && (count_ff != 2'd2);
   assign pop        = status.pop && (count_ff != 2'd0);
   assign set_val    = IS_POW2 ? (addr_ff[SET_W-1:0] & SET_W'(NUM_SETS - 1))
                               : rem_ff[SET_W-1:0];

   always_comb begin
      r = rem_ff;
      for (int k = 0; k < MOD_STEP; k++) begin
         r = {r[SET_W-1:0], sh_ff[ADDR_W-1-k]};
         if (r >= (SET_W+1)'(NUM_SETS)) begin
            r = r - (SET_W+1)'(NUM_SETS);
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      rtype_in = rtype_ff;
      addr_in  = addr_ff;
      sh_in    = sh_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         busy_in  = 1'b1;
         rtype_in = req_tuser;
         addr_in  = req_tdata;
         sh_in    = req_tdata;
         rem_in   = '0;
         cnt_in   = '0;
      end else if (busy_ff && !done) begin
         rem_in = r;
         sh_in  = sh_ff << MOD_STEP;
         cnt_in = cnt_ff + 1'b1;
      end else if (push) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         wp_ff    <= 1'b0;
         rp_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      rtype_ff <= rtype_in;
      addr_ff  <= addr_in;
      sh_ff    <= sh_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (push) begin
         q_rtype_ff[wp_ff] <= rtype_ff;
         q_addr_ff[wp_ff]  <= addr_ff;
         q_set_ff[wp_ff]   <= set_val;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.rtype = q_rtype_ff[rp_ff];
   assign head.addr  = q_addr_ff[rp_ff];
   assign head_set   = q_set_ff[rp_ff];

endmodule

// ===== rtl/sacts_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacts_back
// set read, lookup, victim choice, set write back and result register
// ----------------------------------------------------------------------------
module sacts_back import sacts_pkg::*; #(
   parameter int NUM_SETS = 1024,
   parameter int NUM_WAYS = 8,
   parameter int SET_W    = 10,
   parameter int WAY_W    = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [POL_W-1:0]      policy,
   input  req_head_type          head,
   input  logic [SET_W-1:0]      head_set,
   output back_status_type       status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam bit IS_WPOW2 = ((NUM_WAYS & (NUM_WAYS - 1)) == 0);
   localparam int NIB      = LFSR_W / MOD_STEP;
   localparam int NIB_W    = $clog2(NIB);

   logic [NUM_WAYS*ADDR_W-1:0]  tag_mem   [NUM_SETS];
   logic [NUM_WAYS*STAMP_W-1:0] stamp_mem [NUM_SETS];
   logic [NUM_WAYS*CTR_W-1:0]   ctr_mem   [NUM_SETS];
   logic [2*NUM_WAYS-1:0]       vd_mem    [NUM_SETS];

   logic [NUM_WAYS*ADDR_W-1:0]  rd_tag_ff;
   logic [NUM_WAYS*STAMP_W-1:0] rd_stamp_ff;
   logic [NUM_WAYS*CTR_W-1:0]   rd_ctr_ff;
   logic [2*NUM_WAYS-1:0]       rd_vd_ff;

   back_state_type state_ff, state_in;

   logic [TYPE_W-1:0]         cur_rtype_ff;
   logic [ADDR_W-1:0]         cur_addr_ff;
   logic [SET_W-1:0]          cur_set_ff;
   logic [SET_W-1:0]          clr_ff, clr_in;
   logic [STAMP_W-1:0]        count_ff, count_in;
   logic [LFSR_W-1:0]         lfsr_ff, lfsr_in;
   logic [WAY_W-1:0]          victim_ff, victim_in;
   logic [NUM_WAYS*CTR_W-1:0] work_ff, work_in;
   logic [WAY_W-1:0]          best_ff, best_in;
   logic [STAMP_W-1:0]        bstamp_ff, bstamp_in;
   logic [WAY_W-1:0]          idx_ff, idx_in;
   logic [WAY_W:0]            rmod_ff, rmod_in;
   logic [NIB_W-1:0]          rnib_ff, rnib_in;
   logic [LFSR_W-1:0]         rsh_ff, rsh_in;
   logic                      rsp_valid_ff;
   logic [RSP_W-1:0]          rsp_data_ff;

   logic                      rd_en, wr_en, clearing, pop, res_load, out_free;
   logic [NUM_WAYS*ADDR_W-1:0]  wr_tag;
   logic [NUM_WAYS*STAMP_W-1:0] wr_stamp;
   logic [NUM_WAYS*CTR_W-1:0]   wr_ctr;
   logic [2*NUM_WAYS-1:0]       wr_vd;
   logic [RSP_W-1:0]            res_data;

   logic [NUM_WAYS-1:0]       match, valid_w;
   logic                      hit_any, inv_any;
   logic [WAY_W-1:0]          hit_way, inv_way, zero_way;
   logic [CTR_W-1:0]          low;
   logic [7:0]                present;
   logic [NUM_WAYS*CTR_W-1:0] lowered;
   logic [LFSR_W-1:0]         lfsr_next;
   logic [WAY_W:0]            rr;
   logic [STAMP_W-1:0]        scan_stamp;
   logic                      known;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign known    = (cur_rtype_ff <= REQ_INSTALL);
   assign lfsr_next = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_MASK : '0);
   assign scan_stamp = rd_stamp_ff[idx_ff*STAMP_W +: STAMP_W];

   always_comb begin
      hit_any  = 1'b0;
      inv_any  = 1'b0;
      hit_way  = '0;
      inv_way  = '0;
      zero_way = '0;
      low      = CTR_HIT;
      present  = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         valid_w[w] = rd_vd_ff[w];
         match[w]   = rd_vd_ff[w] && (rd_tag_ff[w*ADDR_W +: ADDR_W] == cur_addr_ff) && known;
         for (int c = 0; c < 8; c++) begin
            if (rd_ctr_ff[w*CTR_W +: CTR_W] == CTR_W'(c)) begin
               present[c] = 1'b1;
            end
         end
      end
      for (int c = 6; c >= 0; c--) begin
         if (present[c]) begin
            low = CTR_W'(c);
         end
      end
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         lowered[w*CTR_W +: CTR_W] = rd_ctr_ff[w*CTR_W +: CTR_W] - low;
         if (match[w]) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!valid_w[w]) begin
            inv_any = 1'b1;
            inv_way = WAY_W'(w);
         end
         if (rd_ctr_ff[w*CTR_W +: CTR_W] == low) begin
            zero_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      rr = rmod_ff;
      for (int k = 0; k < MOD_STEP; k++) begin
         rr = {rr[WAY_W-1:0], rsh_ff[LFSR_W-1-k]};
         if (rr >= (WAY_W+1)'(NUM_WAYS)) begin
            rr = rr - (WAY_W+1)'(NUM_WAYS);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      count_in  = count_ff;
      lfsr_in   = lfsr_ff;
      victim_in = victim_ff;
      work_in   = work_ff;
      best_in   = best_ff;
      bstamp_in = bstamp_ff;
      idx_in    = idx_ff;
      rmod_in   = rmod_ff;
      rnib_in   = rnib_ff;
      rsh_in    = rsh_ff;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      clearing  = 1'b0;
      pop       = 1'b0;
      res_load  = 1'b0;
      wr_tag    = rd_tag_ff;
      wr_stamp  = rd_stamp_ff;
      wr_ctr    = rd_ctr_ff;
      wr_vd     = rd_vd_ff;
      res_data  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing = 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            work_in = rd_ctr_ff;
            if (cur_rtype_ff == REQ_INSTALL && !hit_any) begin
               if (inv_any) begin
                  victim_in = inv_way;
                  state_in  = ST_APPLY;
               end else if (policy == POL_RANDOM) begin
                  lfsr_in = lfsr_next;
                  if (IS_WPOW2) begin
                     victim_in = lfsr_next[WAY_W-1:0] & WAY_W'(NUM_WAYS - 1);
                     state_in  = ST_APPLY;
                  end else begin
                     rsh_in   = lfsr_next;
                     rmod_in  = '0;
                     rnib_in  = '0;
                     state_in = ST_RMOD;
                  end
               end else if (policy == POL_REUSE) begin
                  work_in   = lowered;
                  victim_in = zero_way;
                  state_in  = ST_APPLY;
               end else if (NUM_WAYS == 1) begin
                  victim_in = '0;
                  state_in  = ST_APPLY;
               end else begin
                  best_in   = '0;
                  bstamp_in = rd_stamp_ff[STAMP_W-1:0];
                  idx_in    = WAY_W'(1);
                  state_in  = ST_SCAN;
               end
            end else if (out_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
               if (cur_rtype_ff == REQ_ACCESS) begin
                  count_in = count_ff + 1'b1;
               end
               if (hit_any) begin
                  priority case (cur_rtype_ff)
                     REQ_ACCESS: begin
                        wr_en = 1'b1;
                        wr_stamp[hit_way*STAMP_W +: STAMP_W] = count_ff + 1'b1;
                        wr_ctr[hit_way*CTR_W +: CTR_W]       = CTR_HIT;
                     end
                     REQ_INVALIDATE: begin
                        wr_en          = 1'b1;
                        wr_vd[hit_way] = 1'b0;
                     end
                     REQ_DIRTY: begin
                        wr_en                     = 1'b1;
                        wr_vd[NUM_WAYS + hit_way] = 1'b1;
                     end
                     default: begin
                        wr_en = 1'b0;
                     end
                  endcase
               end
               res_data = {7'd0, {ADDR_W{1'b0}}, 1'b0, 1'b0,
                           (cur_rtype_ff == REQ_INSTALL) && hit_any,
                           10'(cur_set_ff), 3'(hit_way & {WAY_W{hit_any}}), hit_any};
            end
         end
         ST_RMOD: begin
            rmod_in = rr;
            rsh_in  = rsh_ff << MOD_STEP;
            rnib_in = rnib_ff + 1'b1;
            if (rnib_ff == NIB_W'(NIB - 1)) begin
               victim_in = rr[WAY_W-1:0];
               state_in  = ST_APPLY;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (scan_stamp < bstamp_ff) begin
               best_in   = idx_ff;
               bstamp_in = scan_stamp;
            end
            if (idx_ff == WAY_W'(NUM_WAYS - 1)) begin
               victim_in = (scan_stamp < bstamp_ff) ? idx_ff : best_ff;
               state_in  = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (out_free) begin
               res_load = 1'b1;
               wr_en    = 1'b1;
               state_in = ST_IDLE;
               wr_tag[victim_ff*ADDR_W +: ADDR_W] = cur_addr_ff;
               wr_stamp[victim_ff*STAMP_W +: STAMP_W] = count_ff;
               wr_ctr = work_ff;
               wr_ctr[victim_ff*CTR_W +: CTR_W] = CTR_NEW;
               wr_vd[victim_ff] = 1'b1;
               wr_vd[NUM_WAYS + victim_ff] = 1'b0;
               res_data = {7'd0,
                  (rd_vd_ff[victim_ff] && rd_vd_ff[NUM_WAYS + victim_ff])
                     ? rd_tag_ff[victim_ff*ADDR_W +: ADDR_W] : {ADDR_W{1'b0}},
                  rd_vd_ff[victim_ff] && rd_vd_ff[NUM_WAYS + victim_ff],
                  rd_vd_ff[victim_ff], 1'b0,
                  10'(cur_set_ff), 3'(victim_ff), 1'b0};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem[cur_set_ff] <= wr_tag;
      end
      if (rd_en) begin
         rd_tag_ff <= tag_mem[head_set];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stamp_mem[cur_set_ff] <= wr_stamp;
      end
      if (rd_en) begin
         rd_stamp_ff <= stamp_mem[head_set];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ctr_mem[cur_set_ff] <= wr_ctr;
      end
      if (rd_en) begin
         rd_ctr_ff <= ctr_mem[head_set];
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         vd_mem[clr_ff] <= '0;
      end else if (wr_en) begin
         vd_mem[cur_set_ff] <= wr_vd;
      end
      if (rd_en) begin
         rd_vd_ff <= vd_mem[head_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
         lfsr_ff  <= lfsr_in;
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      victim_ff <= victim_in;
      work_ff   <= work_in;
      best_ff   <= best_in;
      bstamp_ff <= bstamp_in;
      idx_ff    <= idx_in;
      rmod_ff   <= rmod_in;
      rnib_ff   <= rnib_in;
      rsh_ff    <= rsh_in;
      if (pop) begin
         cur_rtype_ff <= head.rtype;
         cur_addr_ff  <= head.addr;
         cur_set_ff   <= head_set;
      end
      if (res_load) begin
         rsp_data_ff <= res_data;
      end
   end

   assign status.pop      = pop;
   assign status.clearing = clearing;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !pop)
      else $error("request popped during clearing pass");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_EVAL || state_ff == ST_APPLY))
      else $error("set written outside update states");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before taken");

   a_dup_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[14]) |-> rsp_data_ff[0])
      else $error("duplicate reported without hit");

   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("lfsr locked at zero");

endmodule

// ===== rtl/set_assoc_cache_tag_store_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store_top
// set-associative tag store with lru, random and reuse counter replacement
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tuser req_type, tdata line_addr
//  rsp      out  rsp_tvalid/rsp_tready  tdata result fields
//  csr      in   csr_wen                csr_wdata replacement_policy
//
//  a request has its set read in ST_IDLE, then lookup and set write back in ST_EVAL
//  an install that misses writes the chosen way in ST_APPLY
//  when NUM_SETS is not a power of two the front end does set reduction serially
//  lru install on a full set scans the way stamps in ST_SCAN
//  random install with NUM_WAYS not a power of two reduces the lfsr in ST_RMOD
//  after reset a clearing pass over all NUM_SETS sets runs before the first request
//  a held result stalls the back end; the two-entry queue, till full, takes requests
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store_top import sacts_pkg::*; #(
   parameter int NUM_SETS = 1024,
   parameter int NUM_WAYS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [TYPE_W-1:0]   req_tuser,   // req_type
   input  logic [ADDR_W-1:0]   req_tdata,   // line_addr
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // found, way_index, set_index, duplicate_error, evicted_valid,
   // evicted_dirty, evict_addr, zero fill
   output logic [RSP_W-1:0]    rsp_tdata,
   input  logic                csr_wen,
   input  logic [POL_W-1:0]    csr_wdata
);

   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

   logic [POL_W-1:0] policy_ff;
   back_status_type  status;
   req_head_type     head;
   logic [SET_W-1:0] head_set;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= '0;
      end else if (csr_wen) begin
         policy_ff <= csr_wdata;
      end
   end

   sacts_front #(
      .NUM_SETS (NUM_SETS),
      .SET_W    (SET_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .status     (status),
      .head       (head),
      .head_set   (head_set)
   );

   sacts_back #(
      .NUM_SETS (NUM_SETS),
      .NUM_WAYS (NUM_WAYS),
      .SET_W    (SET_W),
      .WAY_W    (WAY_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .policy     (policy_ff),
      .head       (head),
      .head_set   (head_set),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives lookup, state-change and install requests into the set-associative
// tag store under each replacement policy. Requests mostly hit a few sets with
// a small pool of tags, so sets fill up and lines get evicted. A scoreboard
// keeps its own copy of the tags, flags, stamps, counters and random state,
// predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
   import sacts_pkg::*;

   localparam int SETS  = 1024;
   localparam int WAYS  = 8;
   localparam int LIMIT = 20000;

   typedef struct {
      logic              found;
      logic [2:0]        way;
      logic [9:0]        set;
      logic              dup;
      logic              ev_valid;
      logic              ev_dirty;
      logic [ADDR_W-1:0] ev_addr;
   } lookup_result_type;

   class tag_store_scoreboard;
      logic [ADDR_W-1:0]  tags[SETS*WAYS];
      bit                 valid[SETS*WAYS];
      bit                 dirty[SETS*WAYS];
      logic [STAMP_W-1:0] stamps[SETS*WAYS];
      logic [CTR_W-1:0]   ctrs[SETS*WAYS];
      logic [STAMP_W-1:0] access_count;
      logic [LFSR_W-1:0]  lfsr;
      logic [POL_W-1:0]   policy;
      lookup_result_type  expected_q[$];
      int                 errors;

      function new();
         foreach (valid[i]) begin
            valid[i] = 0;
            dirty[i] = 0;
            stamps[i] = '0;
            ctrs[i] = '0;
            tags[i] = '0;
         end
         access_count = '0;
         lfsr = LFSR_SEED;
         policy = '0;
         errors = 0;
      endfunction

      function int choose_victim(int base);
         logic [CTR_W-1:0] low;
         int best;
         for (int w = 0; w < WAYS; w++) begin
            if (!valid[base+w]) return w;
         end
         if (policy == POL_RANDOM) begin
            lfsr = (lfsr >> 1) ^ (lfsr[0] ? LFSR_MASK : '0);
            return int'(lfsr % WAYS);
         end
         if (policy == POL_REUSE) begin
            low = 3'd7;
            for (int w = 0; w < WAYS; w++) if (ctrs[base+w] < low) low = ctrs[base+w];
            for (int w = 0; w < WAYS; w++) ctrs[base+w] = ctrs[base+w] - low;
            for (int w = 0; w < WAYS; w++) if (ctrs[base+w] == 0) return w;
            return 0;
         end
         best = 0;
         for (int w = 1; w < WAYS; w++) if (stamps[base+w] < stamps[base+best]) best = w;
         return best;
      endfunction

      function void note_request(logic [TYPE_W-1:0] rtype, logic [ADDR_W-1:0] addr);
         lookup_result_type r;
         int set, base, hit, v;
         set = int'(addr % SETS);
         base = set * WAYS;
         r = '{default: '0};
         r.set = set[9:0];
         hit = -1;
         for (int w = 0; w < WAYS; w++) begin
            if (hit < 0 && valid[base+w] && tags[base+w] == addr) hit = w;
         end
         if (rtype <= REQ_DIRTY) begin
            if (rtype == REQ_ACCESS) access_count++;
            if (hit >= 0) begin
               r.found = 1;
               r.way = hit[2:0];
               case (rtype)
                  REQ_ACCESS: begin
                     stamps[base+hit] = access_count;
                     ctrs[base+hit] = CTR_HIT;
                  end
                  REQ_INVALIDATE: valid[base+hit] = 0;
                  REQ_DIRTY: dirty[base+hit] = 1;
                  default: ;
               endcase
            end
         end else if (rtype == REQ_INSTALL) begin
            if (hit >= 0) begin
               r.found = 1;
               r.way = hit[2:0];
               r.dup = 1;
            end else begin
               v = choose_victim(base);
               if (valid[base+v]) begin
                  r.ev_valid = 1;
                  if (dirty[base+v]) begin
                     r.ev_dirty = 1;
                     r.ev_addr = tags[base+v];
                  end
               end
               tags[base+v] = addr;
               valid[base+v] = 1;
               dirty[base+v] = 0;
               ctrs[base+v] = CTR_NEW;
               stamps[base+v] = access_count;
               r.way = v[2:0];
            end
         end
         expected_q.push_back(r);
      endfunction

      function void compare(string name, logic [ADDR_W-1:0] e, logic [ADDR_W-1:0] a);
         if (e !== a) begin
            $error("%s expected %0h actual %0h", name, e, a);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] d);
         lookup_result_type e;
         if (expected_q.size() == 0) begin
            $error("response beat with nothing expected: %0h", d);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare("found", e.found, d[0]);
         compare("way_index", e.way, d[3:1]);
         compare("set_index", e.set, d[13:4]);
         compare("duplicate_error", e.dup, d[14]);
         compare("evicted_valid", e.ev_valid, d[15]);
         compare("evicted_dirty", e.ev_dirty, d[16]);
         compare("evict_addr", e.ev_addr, d[64:17]);
         compare("zero fill", '0, d[71:65]);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [TYPE_W-1:0] req_tuser;
   logic [ADDR_W-1:0] req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_wen;
   logic [POL_W-1:0]  csr_wdata;

   tag_store_scoreboard sb;
   int req_beats;
   int quiet_cycles;
   int send_idle_pct;
   int recv_idle_pct;
   logic [ADDR_W-1:0] tag_pool[12];
   int set_pool[4];

   set_assoc_cache_tag_store_top #(.NUM_SETS(SETS), .NUM_WAYS(WAYS)) u_top (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tuser, req_tdata);
            req_beats++;
            quiet_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_request(logic [TYPE_W-1:0] rtype, logic [ADDR_W-1:0] addr);
      int seen;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tuser = rtype;
      req_tdata = addr;
      seen = req_beats;
      do @(negedge clock); while (req_beats == seen);
   endtask

   task automatic drain();
      req_tvalid = 0;
      @(negedge clock);
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_policy(logic [POL_W-1:0] pol);
      csr_wen = 1;
      csr_wdata = pol;
      sb.policy = pol;
      @(negedge clock);
      csr_wen = 0;
   endtask

   function automatic logic [ADDR_W-1:0] pick_addr();
      logic [ADDR_W-1:0] a;
      if ($urandom_range(9) == 0) begin
         a = ADDR_W'({$urandom, $urandom});
         return a;
      end
      a = tag_pool[$urandom_range(11)];
      a[9:0] = 10'(set_pool[$urandom_range(3)]);
      return a;
   endfunction

   function automatic logic [TYPE_W-1:0] pick_type();
      int r;
      r = $urandom_range(99);
      if (r < 35) return REQ_INSTALL;
      if (r < 65) return REQ_ACCESS;
      if (r < 75) return REQ_PROBE;
      if (r < 83) return REQ_INVALIDATE;
      if (r < 95) return REQ_DIRTY;
      return TYPE_W'($urandom_range(7));
   endfunction

   initial begin
      logic [ADDR_W-1:0] all_ones;
      sb = new();
      req_beats = 0;
      quiet_cycles = 0;
      send_idle_pct = 17;
      recv_idle_pct = 65;
      reset = 1;
      req_tvalid = 0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 0;
      csr_wen = 0;
      csr_wdata = '0;
      all_ones = '1;
      repeat (5) @(negedge clock);
      reset = 0;

      // directed: edges of the address, every request kind, full-set eviction
      write_policy(2'd0);
      send_request(REQ_INSTALL, '0);
      send_request(REQ_INSTALL, all_ones);
      send_request(REQ_ACCESS, all_ones);
      send_request(REQ_PROBE, '0);
      send_request(REQ_DIRTY, '0);
      send_request(REQ_INSTALL, '0);
      send_request(REQ_INVALIDATE, all_ones);
      send_request(REQ_PROBE, all_ones);
      send_request(REQ_ACCESS, 48'h1234);
      for (int i = 1; i <= 8; i++) send_request(REQ_INSTALL, 48'd5 + 48'(i) * SETS);
      send_request(REQ_DIRTY, 48'd5 + 48'd1 * SETS);
      send_request(REQ_ACCESS, 48'd5 + 48'd2 * SETS);
      send_request(REQ_INSTALL, 48'd5 + 48'd9 * SETS);
      send_request(REQ_INSTALL, 48'd5 + 48'd10 * SETS);
      send_request(3'd5, all_ones);
      send_request(3'd6, 48'd77);
      send_request(3'd7, all_ones);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         case (ph / 3)
            0: begin send_idle_pct = 17; recv_idle_pct = 65; end
            1: begin send_idle_pct = 65; recv_idle_pct = 17; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         write_policy(POL_W'(ph % 4));
         foreach (tag_pool[i]) tag_pool[i] = ADDR_W'({$urandom, $urandom});
         set_pool[0] = 0;
         set_pool[1] = SETS - 1;
         set_pool[2] = $urandom_range(SETS - 1);
         set_pool[3] = $urandom_range(SETS - 1);
         for (int n = 0; n < 210; n++) send_request(pick_type(), pick_addr());
         drain();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
